[hw/rtl/ptt_pkg.sv]
`timescale 1ns / 1ps

package ptt_pkg;

    localparam int NUM_TIMERS_DEFAULT = 16;
    localparam logic [9:0] TICK_PERIOD_RESET = 10'd10;

    localparam int TIME_W   = 32;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam logic REG_TICK_PERIOD = 1'b0;

    typedef enum logic [1:0] {
        FUNC_ADD_REC = 2'd0,
        FUNC_ADD_ONE = 2'd1,
        FUNC_REMOVE  = 2'd2,
        FUNC_TICK    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        KIND_ADDED   = 2'd0,
        KIND_REMOVED = 2'd1,
        KIND_FIRED   = 2'd2,
        KIND_DONE    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_FULL     = 2'd1,
        ERR_NO_TIMER = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FIND,
        ST_CHK,
        ST_DONE
    } state_t;

    typedef struct packed {
        func_t              func;
        logic [3:0]         timer_id;
        logic [TIME_W-1:0]  period_ms;
        logic [7:0]         topic;
        logic [15:0]        payload;
        logic [TIME_W-1:0]  now_ms;
    } req_t;

    typedef struct packed {
        kind_t              result_kind;
        logic [3:0]         slot_id;
        logic [7:0]         fired_topic;
        logic [15:0]        fired_payload;
        err_t               error_code;
        logic               last;
    } res_t;

    typedef struct packed {
        logic [TIME_W-1:0]  period;
        logic [TIME_W-1:0]  armed_ms;
        logic               recurring;
        logic [7:0]         topic;
        logic [15:0]        payload;
    } slot_t;

endpackage

[hw/rtl/ptt_ram.sv]
`timescale 1ns / 1ps

module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/ptt_cmp.sv]
`timescale 1ns / 1ps

module ptt_cmp
    import ptt_pkg::*;
(
    input  logic [TIME_W-1:0] now_ms,
    input  logic [TIME_W-1:0] since_ms,
    input  logic [TIME_W-1:0] limit_ms,
    output logic              elapsed
);

    logic [TIME_W-1:0] diff;

    assign diff    = now_ms - since_ms;
    assign elapsed = (diff >= limit_ms);

endmodule

[hw/rtl/ptt_apb.sv]
`timescale 1ns / 1ps

module ptt_apb
    import ptt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [9:0]        tick_period
);

    logic [9:0] tick_period_reg;
    logic [9:0] tick_period_next;
    logic       hit;

    assign hit    = (paddr[APB_AW-1] == REG_TICK_PERIOD);
    assign pready = 1'b1;

    always_comb
    begin
        tick_period_next = tick_period_reg;
        if (psel && penable && pwrite && hit)
        begin
            tick_period_next = pwdata[9:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_period_reg <= TICK_PERIOD_RESET;
        end
        else
        begin
            tick_period_reg <= tick_period_next;
        end
    end

    assign prdata      = hit ? APB_DW'(tick_period_reg) : '0;
    assign tick_period = tick_period_reg;

endmodule

[hw/rtl/ptt_seq.sv]
`timescale 1ns / 1ps

module ptt_seq
    import ptt_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEFAULT,
    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1,
    localparam int SLOT_W = $bits(slot_t)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req,
    output logic              res_valid,
    input  logic              res_ready,
    output res_t              res,
    input  logic [9:0]        tick_period,
    output logic              ram_we,
    output logic [IDX_W-1:0]  ram_waddr,
    output logic [SLOT_W-1:0] ram_wdata,
    output logic              ram_re,
    output logic [IDX_W-1:0]  ram_raddr,
    input  logic [SLOT_W-1:0] ram_rdata,
    output logic [TIME_W-1:0] cmp_now,
    output logic [TIME_W-1:0] cmp_since,
    output logic [TIME_W-1:0] cmp_limit,
    input  logic              cmp_elapsed
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    req_t                    req_reg, req_next;
    res_t                    res_reg, res_next;
    logic                    res_valid_reg, res_valid_next;
    logic [NUM_TIMERS-1:0]   valid_reg, valid_next;
    logic [TIME_W-1:0]       last_scan_reg, last_scan_next;
    logic                    scanned_reg, scanned_next;

    slot_t                   rd_slot;
    slot_t                   wr_slot;
    logic                    out_free;
    logic                    rm_in_range;
    logic [IDX_W-1:0]        rm_idx;
    logic                    rm_hit;
    logic                    slot_hit;

    assign rd_slot     = slot_t'(ram_rdata);
    assign ram_wdata   = SLOT_W'(wr_slot);
    assign out_free    = !res_valid_reg || res_ready;
    assign rm_in_range = (32'(req_reg.timer_id) < 32'(NUM_TIMERS));
    assign rm_idx      = IDX_W'(req_reg.timer_id);
    assign rm_hit      = rm_in_range && valid_reg[rm_idx];
    assign slot_hit    = valid_reg[idx_reg] && cmp_elapsed;

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        cmp_now = req_reg.now_ms;
        if (state_reg == ST_DECODE)
        begin
            cmp_since = last_scan_reg;
            cmp_limit = TIME_W'(tick_period);
        end
        else
        begin
            cmp_since = rd_slot.armed_ms;
            cmp_limit = rd_slot.period;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_ready;
        valid_next     = valid_reg;
        last_scan_next = last_scan_reg;
        scanned_next   = scanned_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_re         = 1'b0;
        ram_raddr      = idx_reg + IDX_W'(1);
        wr_slot        = rd_slot;
        wr_slot.armed_ms = req_reg.now_ms;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                unique case (req_reg.func)
                    FUNC_ADD_REC, FUNC_ADD_ONE:
                    begin
                        idx_next   = '0;
                        state_next = ST_FIND;
                    end
                    FUNC_REMOVE:
                    begin
                        if (out_free)
                        begin
                            res_next.result_kind   = KIND_REMOVED;
                            res_next.slot_id       = req_reg.timer_id;
                            res_next.fired_topic   = '0;
                            res_next.fired_payload = '0;
                            res_next.error_code    = rm_hit ? ERR_NONE : ERR_NO_TIMER;
                            res_next.last          = 1'b1;
                            res_valid_next         = 1'b1;
                            if (rm_hit)
                            begin
                                valid_next[rm_idx] = 1'b0;
                            end
                            state_next = ST_IDLE;
                        end
                    end
                    FUNC_TICK:
                    begin
                        if (!scanned_reg || cmp_elapsed)
                        begin
                            scanned_next   = 1'b1;
                            last_scan_next = req_reg.now_ms;
                            idx_next       = '0;
                            ram_re         = 1'b1;
                            ram_raddr      = '0;
                            state_next     = ST_CHK;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                endcase
            end

            ST_FIND:
            begin
                if (!valid_reg[idx_reg])
                begin
                    if (out_free)
                    begin
                        ram_we                 = 1'b1;
                        wr_slot.period         = req_reg.period_ms;
                        wr_slot.armed_ms       = req_reg.now_ms;
                        wr_slot.recurring      = (req_reg.func == FUNC_ADD_REC);
                        wr_slot.topic          = req_reg.topic;
                        wr_slot.payload        = req_reg.payload;
                        valid_next[idx_reg]    = 1'b1;
                        res_next.result_kind   = KIND_ADDED;
                        res_next.slot_id       = 4'(idx_reg);
                        res_next.fired_topic   = '0;
                        res_next.fired_payload = '0;
                        res_next.error_code    = ERR_NONE;
                        res_next.last          = 1'b1;
                        res_valid_next         = 1'b1;
                        state_next             = ST_IDLE;
                    end
                end
                else if (idx_reg == LAST_IDX)
                begin
                    if (out_free)
                    begin
                        res_next.result_kind   = KIND_ADDED;
                        res_next.slot_id       = '0;
                        res_next.fired_topic   = '0;
                        res_next.fired_payload = '0;
                        res_next.error_code    = ERR_FULL;
                        res_next.last          = 1'b1;
                        res_valid_next         = 1'b1;
                        state_next             = ST_IDLE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            ST_CHK:
            begin
                if (!slot_hit || out_free)
                begin
                    if (slot_hit)
                    begin
                        res_next.result_kind   = KIND_FIRED;
                        res_next.slot_id       = 4'(idx_reg);
                        res_next.fired_topic   = rd_slot.topic;
                        res_next.fired_payload = rd_slot.payload;
                        res_next.error_code    = ERR_NONE;
                        res_next.last          = 1'b0;
                        res_valid_next         = 1'b1;
                        if (rd_slot.recurring)
                        begin
                            ram_we = 1'b1;
                        end
                        else
                        begin
                            valid_next[idx_reg] = 1'b0;
                        end
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                        ram_re   = 1'b1;
                    end
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    res_next.result_kind   = KIND_DONE;
                    res_next.slot_id       = '0;
                    res_next.fired_topic   = '0;
                    res_next.fired_payload = '0;
                    res_next.error_code    = ERR_NONE;
                    res_next.last          = 1'b1;
                    res_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
            valid_reg     <= '0;
            last_scan_reg <= '0;
            scanned_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
            valid_reg     <= valid_next;
            last_scan_reg <= last_scan_next;
            scanned_reg   <= scanned_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        res_reg <= res_next;
    end

endmodule

[hw/rtl/periodic_oneshot_timer_table.sv]
`timescale 1ns / 1ps
// Channel   Signals                                    Moves
// req       req_valid / req_ready / req (req_t)        one add, remove or tick request
// res       res_valid / res_ready / res (res_t)        one result, last marks the final one
// apb       psel penable pwrite paddr pwdata prdata    tick period register at 0x0
//
// Add tests one slot per cycle and waits at a free slot while a result is held.
// Tick goes to its done result when gated out, else it scans one slot per cycle, unless
// a held result blocks a firing slot, via the slot RAM and one shared subtract-compare.
// Reset clears the slot valid flops at once; no clearing pass follows.
// A held result stalls the sequencer only when it has a new result to place.

module periodic_oneshot_timer_table
    import ptt_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req,
    output logic              res_valid,
    input  logic              res_ready,
    output res_t              res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int SLOT_W = $bits(slot_t);

    logic [9:0]        tick_period;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [SLOT_W-1:0] ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [SLOT_W-1:0] ram_rdata;
    logic [TIME_W-1:0] cmp_now;
    logic [TIME_W-1:0] cmp_since;
    logic [TIME_W-1:0] cmp_limit;
    logic              cmp_elapsed;

    ptt_apb u_apb (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .tick_period (tick_period)
    );

    ptt_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (NUM_TIMERS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ptt_cmp u_cmp (
        .now_ms   (cmp_now),
        .since_ms (cmp_since),
        .limit_ms (cmp_limit),
        .elapsed  (cmp_elapsed)
    );

    ptt_seq #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .tick_period (tick_period),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .cmp_now     (cmp_now),
        .cmp_since   (cmp_since),
        .cmp_limit   (cmp_limit),
        .cmp_elapsed (cmp_elapsed)
    );

endmodule
